>>> src/frfc_pkg.sv
// Package for the finite radix fraction check block.
// Holds the default operand width and the reset value of the base register.
// No dependencies.
package frfc_pkg;

  // Default width of the denominator, the base and the divider datapath.
  localparam int VALUE_BITS_DEF = 31;

  // Base register value after reset.
  localparam int RADIX_RESET = 10;

endpackage

>>> src/finite_radix_fraction_check_core.sv
// Top level of the finite radix fraction check block.
// Sequencer, base register and result register; uses frfc_div and frfc_pkg.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------
//   cfg      | cfg_valid / cfg_ready  | radix_base
//   in       | in_valid  / in_ready   | denom_value
//   out      | out_valid / out_ready  | not_finite, bad_denom
//
// Each item is worked on alone. A zero denominator goes from idle straight to done.
// Otherwise every Euclid remainder step and every reduction d / gcd costs one
// pass of the shared divider, so the time an item takes grows with the number
// of divider passes. in_ready is high only while the sequencer is idle, and a
// finished result waits in the output register while the next item is taken.
// Reset (rst, synchronous) clears the sequencer and output valid and loads the
// base register with 10. Configuration writes are always accepted.
module finite_radix_fraction_check_core #(
  parameter int VALUE_BITS = frfc_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [VALUE_BITS-1:0] radix_base,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] denom_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  not_finite,
  output logic                  bad_denom
);
  import frfc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD_TEST,
    S_GCD_WAIT,
    S_RED_WAIT,
    S_DONE
  } state_t;

  state_t state;

  // base is the configured radix; d is the denominator being reduced; a and c
  // are the Euclid pair for gcd(d, base).
  logic [VALUE_BITS-1:0] base;
  logic [VALUE_BITS-1:0] d;
  logic [VALUE_BITS-1:0] a;
  logic [VALUE_BITS-1:0] c;
  logic                  res_nf;
  logic                  res_bad;

  logic                  div_start;
  logic [VALUE_BITS-1:0] div_num;
  logic [VALUE_BITS-1:0] div_den;
  logic                  div_busy;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quo;
  logic [VALUE_BITS-1:0] div_rem;
  logic                  gcd_found;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  // When c reaches zero the gcd sits in a. A gcd other than one means d is
  // divided by it; otherwise the next Euclid step computes a mod c.
  assign gcd_found = (c == '0);
  assign div_start = (state == S_GCD_TEST) && !(gcd_found && a == VALUE_BITS'(1));
  assign div_num   = gcd_found ? d : a;
  assign div_den   = gcd_found ? a : c;

  frfc_div #(
    .W (VALUE_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      base      <= VALUE_BITS'(RADIX_RESET);
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        base <= radix_base;
      end
      // In S_DONE the case arm below owns out_valid.
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (denom_value == '0) begin
              res_bad <= 1'b1;
              res_nf  <= 1'b0;
              state   <= S_DONE;
            end else begin
              res_bad <= 1'b0;
              d       <= denom_value;
              a       <= denom_value;
              c       <= base;
              state   <= S_GCD_TEST;
            end
          end
        end
        S_GCD_TEST: begin
          if (gcd_found && a == VALUE_BITS'(1)) begin
            // No common factor left: finite exactly when d is down to one.
            res_nf <= (d != VALUE_BITS'(1));
            state  <= S_DONE;
          end else if (gcd_found) begin
            state <= S_RED_WAIT;
          end else begin
            state <= S_GCD_WAIT;
          end
        end
        S_GCD_WAIT: begin
          if (div_done) begin
            a     <= c;
            c     <= div_rem;
            state <= S_GCD_TEST;
          end
        end
        S_RED_WAIT: begin
          if (div_done) begin
            d     <= div_quo;
            a     <= div_quo;
            c     <= base;
            state <= S_GCD_TEST;
          end
        end
        S_DONE: begin
          // Wait for the output register to be free, then hand the result over.
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            not_finite <= res_nf;
            bad_denom  <= res_bad;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A zero denominator is never also reported as not finite.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(bad_denom && not_finite))
    else $error("bad_denom and not_finite both set");

  // The Euclid pair never degenerates to a zero gcd candidate.
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_GCD_TEST) |-> a != '0)
    else $error("gcd candidate is zero");

  // Once an item is taken the block stops accepting until it is finished.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted twice in a row");

  // The sequencer only waits on the divider while it is running or finishing.
  a_wait_has_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_GCD_WAIT || state == S_RED_WAIT) |-> (div_busy || div_done))
    else $error("waiting on an idle divider");

endmodule

>>> src/frfc_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on frfc_pkg for the default operand width.
module frfc_div #(
  parameter int W = frfc_pkg::VALUE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem
);
  import frfc_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] count;
  logic [W-1:0]  q;
  logic [W-1:0]  r;
  logic [W-1:0]  dsr;
  logic [W:0]    trial;
  logic [W:0]    diff;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {r, q[W-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(W);
        q     <= num;
        r     <= '0;
        dsr   <= den;
      end else if (busy) begin
        if (!diff[W]) begin
          r <= diff[W-1:0];
          q <= {q[W-2:0], 1'b1};
        end else begin
          r <= trial[W-1:0];
          q <= {q[W-2:0], 1'b0};
        end
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = q;
  assign rem = r;

  // A new division must never be started on top of one in flight.
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");

  // The sequencer only ever divides by a nonzero value.
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst) start |-> den != '0)
    else $error("divider started with zero divisor");

  // Done follows the busy period and is a single pulse.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held for more than one cycle");

endmodule

>>> sim/frfc_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the finite radix fraction check block.
// Watches the config, input and result channels and predicts each verdict.
// Depends on frfc_pkg for the default width and the base reset value.
module frfc_result_checker #(
  parameter int VALUE_BITS = frfc_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [VALUE_BITS-1:0] radix_base,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [VALUE_BITS-1:0] denom_value,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  not_finite,
  input  logic                  bad_denom,
  output int                    fail_count,
  output int                    open_count
);

  typedef struct packed {
    bit [VALUE_BITS-1:0] denom;
    bit                  not_finite;
    bit                  bad_denom;
  } fraction_verdict_t;

  bit [VALUE_BITS-1:0] base_copy;
  fraction_verdict_t   pending_verdicts[$];
  int                  mismatches;

  // Strip from the denominator every factor it shares with the base; whatever
  // is left over holds the prime factors that the base lacks.
  function automatic fraction_verdict_t classify_denominator(bit [VALUE_BITS-1:0] denom,
                                                             bit [VALUE_BITS-1:0] base);
    fraction_verdict_t   verdict;
    bit [VALUE_BITS-1:0] rest;
    bit [VALUE_BITS-1:0] x;
    bit [VALUE_BITS-1:0] y;
    bit [VALUE_BITS-1:0] t;
    verdict.denom      = denom;
    verdict.bad_denom  = (denom == 0);
    verdict.not_finite = 1'b0;
    if (denom != 0) begin
      rest = denom;
      do begin
        x = rest;
        y = base;
        while (y != 0) begin
          t = x % y;
          x = y;
          y = t;
        end
        if (x != 1) rest = rest / x;
      end while (x != 1);
      verdict.not_finite = (rest != 1);
    end
    return verdict;
  endfunction

  // The counters start at zero as two-state variables; the base copy is loaded
  // while reset is held.
  always @(posedge clk) begin
    fraction_verdict_t want;
    if (rst) begin
      base_copy = frfc_pkg::RADIX_RESET;
    end else begin
      if (cfg_valid && cfg_ready) base_copy = radix_base;
      if (in_valid && in_ready) pending_verdicts.push_back(classify_denominator(denom_value,
                                                                                base_copy));
      if (out_valid && out_ready) begin
        if (pending_verdicts.size() == 0) begin
          $error("unexpected result item: not_finite %0d, bad_denom %0d", not_finite,
                 bad_denom);
          mismatches++;
        end else begin
          want = pending_verdicts.pop_front();
          if (not_finite !== want.not_finite) begin
            $error("not_finite mismatch for denominator %0d: expected %0d, actual %0b",
                   want.denom, want.not_finite, not_finite);
            mismatches++;
          end
          if (bad_denom !== want.bad_denom) begin
            $error("bad_denom mismatch for denominator %0d: expected %0d, actual %0b",
                   want.denom, want.bad_denom, bad_denom);
            mismatches++;
          end
        end
      end
    end
    fail_count <= mismatches;
    open_count <= pending_verdicts.size();
  end

endmodule

>>> sim/tb_finite_radix_fraction_check_core.sv
`timescale 1ns / 100ps
// Testbench top for finite_radix_fraction_check_core: clock, reset, stimulus
// and verdict. Depends on frfc_pkg, the block itself and frfc_result_checker.
module tb_finite_radix_fraction_check_core;

  localparam int VB = frfc_pkg::VALUE_BITS_DEF;

  // A safe margin, built from divider passes and the sequencer overhead, for the
  // block to fall quiet after the last result item has left it.
  localparam int SETTLE_CYCLES = 2 * (VB + 2) + 4;

  localparam logic [VB-1:0] DENOM_MAX = '1;

  // Product of the first nine primes, the most distinct factors that fit.
  localparam logic [VB-1:0] PRIMORIAL_23 = 223092870;

  logic          clk;
  logic          rst;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [VB-1:0] radix_base;
  logic          in_valid;
  logic          in_ready;
  logic [VB-1:0] denom_value;
  logic          out_valid;
  logic          out_ready;
  logic          not_finite;
  logic          bad_denom;

  int            fail_count;
  int            open_count;

  // The base currently loaded, used to shape the random denominators, and the
  // largest idle gap each side may draw in the present phase.
  logic [VB-1:0] cur_base;
  int            in_gap_max;
  int            out_gap_max;

  finite_radix_fraction_check_core #(.VALUE_BITS(VB)) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .radix_base (radix_base),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .denom_value(denom_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .not_finite (not_finite),
    .bad_denom  (bad_denom)
  );

  frfc_result_checker #(.VALUE_BITS(VB)) result_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .radix_base (radix_base),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .denom_value(denom_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .not_finite (not_finite),
    .bad_denom  (bad_denom),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs, set well beyond the length of a normal run.
  initial begin
    #80_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Every task below is entered and left at a falling edge, so all inputs of
  // the block change away from the rising edge that samples them.

  // Offers one denominator after a random gap. On return the item has been
  // taken and in_valid is still high; the next call either lowers it for a gap
  // or puts the next payload straight on, so valid never drops and rises
  // again within one time step.
  task automatic send_denom(input logic [VB-1:0] d);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    denom_value <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drops the input channel, then waits until every expected result item has
  // come back and the block has had time to go quiet.
  task automatic wait_until_settled();
    in_valid <= 1'b0;
    while (open_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes the base register while the block is idle and draws the idling
  // style for the phase that follows. Some phases run with no gaps at all.
  task automatic load_radix(input logic [VB-1:0] base);
    cfg_valid  <= 1'b1;
    radix_base <= base;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid   <= 1'b0;
    cur_base     = base;
    in_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 18;
    out_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : 18;
  endtask

  // Random denominators. Plain random values would almost never be finite in
  // a large base, so four items in ten are built from the base itself and from
  // small primes, with a stray cofactor thrown in now and then to break the
  // result. The rest are full-width noise, small values (zero among them)
  // and powers of two.
  task automatic send_random_denoms(input int count);
    int              kind;
    int              rounds;
    longint unsigned prod;
    longint unsigned f;
    logic [VB-1:0]   d;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        d = VB'($urandom());
      end else if (kind < 5) begin
        d = VB'($urandom_range(0, 1000));
      end else if (kind == 5) begin
        d = VB'(1) << $urandom_range(0, VB - 1);
      end else begin
        prod   = 1;
        rounds = $urandom_range(1, 8);
        repeat (rounds) begin
          if ($urandom_range(0, 1) == 1) begin
            f = cur_base;
          end else begin
            case ($urandom_range(0, 5))
              0:       f = 2;
              1:       f = 3;
              2:       f = 5;
              3:       f = 7;
              4:       f = 11;
              default: f = 13;
            endcase
          end
          if (f != 0 && prod * f <= DENOM_MAX) prod = prod * f;
        end
        if ($urandom_range(0, 2) == 0) begin
          f = $urandom_range(2, 200);
          if (prod * f <= DENOM_MAX) prod = prod * f;
        end
        d = prod[VB-1:0];
      end
      send_denom(d);
    end
  endtask

  // Phase-level idling on the result side: before each result item the
  // receiver holds ready low for a drawn number of cycles. A draw of zero keeps
  // ready high across the next acceptance.
  initial begin
    int gap;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = $urandom_range(0, out_gap_max);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    radix_base  = '0;
    in_valid    = 1'b0;
    denom_value = '0;
    cur_base    = frfc_pkg::RADIX_RESET;
    in_gap_max  = 18;
    out_gap_max = 18;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed items in the reset base of ten: the zero denominator, one,
    // the base's own primes and their powers, a foreign prime, the widest
    // values, alternating bit patterns and a denominator with many distinct
    // prime factors.
    send_denom(0);
    send_denom(1);
    send_denom(2);
    send_denom(5);
    send_denom(10);
    send_denom(3);
    send_denom(1000);
    send_denom(1220703125);
    send_denom(VB'(1) << (VB - 1));
    send_denom(DENOM_MAX);
    send_denom(PRIMORIAL_23);
    send_denom(VB'(32'h5555_5555));
    send_denom(VB'(32'h2AAA_AAAA));
    send_random_denoms(120);
    wait_until_settled();

    // Base one: only a denominator of one is finite.
    load_radix(1);
    send_denom(1);
    send_denom(0);
    send_denom(2);
    send_random_denoms(120);
    wait_until_settled();

    // Base zero is allowed by the port; every nonzero denominator is then finite.
    load_radix(0);
    send_denom(1);
    send_denom(DENOM_MAX);
    send_random_denoms(120);
    wait_until_settled();

    // The largest base, which happens to be prime.
    load_radix(DENOM_MAX);
    send_denom(DENOM_MAX);
    send_denom(2);
    send_random_denoms(120);
    wait_until_settled();

    // A base holding many distinct primes, so long products stay finite.
    load_radix(PRIMORIAL_23);
    send_denom(PRIMORIAL_23);
    send_denom(PRIMORIAL_23 * VB'(2));
    send_denom(29);
    send_random_denoms(120);
    wait_until_settled();

    load_radix(2);
    send_random_denoms(120);
    wait_until_settled();

    load_radix(6);
    send_random_denoms(120);
    wait_until_settled();

    load_radix(VB'(1) << (VB - 1));
    send_random_denoms(120);
    wait_until_settled();

    // Arbitrary bases from three up to the largest value.
    repeat (2) begin
      load_radix(VB'($urandom_range(3, DENOM_MAX)));
      send_random_denoms(120);
      wait_until_settled();
    end

    // Back to the reset value, this time by an explicit write.
    load_radix(frfc_pkg::RADIX_RESET);
    send_random_denoms(120);
    wait_until_settled();

    if (fail_count == 0 && open_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
